FILE: hdl/bgi_pkg.sv
// Shared widths, codes and state types for the bilinear grid interpolator.
// Used by bgi_div and the top level; depends on nothing.
package bgi_pkg;

   localparam int MAX_X      = 64;
   localparam int MAX_Y      = 64;
   localparam int IX_W       = 6;
   localparam int IY_W       = 6;
   localparam int GADDR_W    = IX_W + IY_W;
   localparam int GRID_DEPTH = MAX_X * MAX_Y;
   localparam int VAL_W      = 32;
   localparam int CNT_W      = 7;
   localparam int DIFF_W     = 33;
   localparam int MUL_W      = 34;
   localparam int PROD_W     = 68;
   localparam int PART_W     = 66;
   localparam int IDXN_W     = 40;
   localparam int ACC_W      = 100;
   localparam int DEN_W      = 66;
   localparam int DCNT_W     = 7;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 40;
   localparam int KIND_W     = 3;
   localparam int STAT_W     = 2;
   localparam int PADDR_W    = 3;
   localparam int PDATA_W    = 32;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_DEGEN = 2'd2;

   localparam logic CSR_IDX_COUNT_X = 1'b0;
   localparam logic CSR_IDX_COUNT_Y = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      RT_WRITE_X   = 3'd0,
      RT_WRITE_Y   = 3'd1,
      RT_WRITE_Z   = 3'd2,
      RT_ADD_Z     = 3'd3,
      RT_WRITE_ALL = 3'd4,
      RT_QUERY     = 3'd5
   } req_kind_type;

   typedef enum logic [3:0] {
      S_IDLE, S_ADD, S_END0, S_END1, S_DIVX, S_DIVY, S_RDA, S_RDB, S_RDC,
      S_RDZ, S_MUL, S_DIVZ, S_OUT
   } fsm_state_type;

endpackage

FILE: hdl/bgi_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered; depends on nothing.
module bgi_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: hdl/bgi_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bgi_pkg for the dividend and divisor widths.
module bgi_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bgi_pkg::ACC_W-1:0]  num,
   input  logic [bgi_pkg::DEN_W-1:0]  den,
   output logic                       done,
   output logic [bgi_pkg::ACC_W-1:0]  quot,
   output logic [bgi_pkg::DEN_W-1:0]  rem
);
   import bgi_pkg::*;

   localparam logic [DCNT_W-1:0] LAST = DCNT_W'(ACC_W - 1);

   logic              busy_ff, done_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic [ACC_W-1:0]  n_ff;
   logic [DEN_W-1:0]  d_ff;
   logic [DEN_W:0]    r_ff, r_sh, r_diff;
   logic              ge;

   assign r_sh   = {r_ff[DEN_W-1:0], n_ff[ACC_W-1]};
   assign ge     = r_sh >= {1'b0, d_ff};
   assign r_diff = r_sh - {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         n_ff <= num;
         d_ff <= den;
         r_ff <= '0;
      end else if (busy_ff) begin
         r_ff <= ge ? r_diff : r_sh;
         n_ff <= {n_ff[ACC_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = n_ff;
   assign rem  = r_ff[DEN_W-1:0];

endmodule

FILE: hdl/bilinear_grid_interpolator_unit.sv
// Top level of the bilinear grid interpolator: sequencer, multiplier and grid memories.
// Depends on bgi_pkg, bgi_ram and bgi_div.
//
//   channel | direction | transfer when              | contents
//   req     | in        | req_tvalid & req_tready    | tuser kind, tdata indices/coords/value
//   rsp     | out       | rsp_tvalid & rsp_tready    | tdata interp_value, status
//   csr     | in        | psel & penable & pwrite    | count_x at 0x0, count_y at 0x4
//
// A write is done on acceptance; an add reads the grid RAM, then writes the sum back.
// A query makes up to three passes through the shared divider of 100 one-bit steps each;
// the rest is RAM reads and the multiplier passes.
// Reset clears the control state and sets both counts to 2; memory contents are not reset.
// A finished result waits in the output register while the next item is accepted.
module bilinear_grid_interpolator_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // index_x, index_y, coord_x, coord_y, data_value, zero pad
   input  logic [bgi_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type
   input  logic [bgi_pkg::KIND_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // interp_value, status, zero pad
   output logic [bgi_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bgi_pkg::PADDR_W-1:0]      csr_paddr,
   input  logic [bgi_pkg::PDATA_W-1:0]      csr_pwdata,
   output logic [bgi_pkg::PDATA_W-1:0]      csr_prdata,
   output logic                             csr_pready
);
   import bgi_pkg::*;

   function automatic logic [DIFF_W-1:0] sdiff(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
      return {a[VAL_W-1], a} - {b[VAL_W-1], b};
   endfunction

   function automatic logic [DIFF_W-1:0] mag33(logic [DIFF_W-1:0] v);
      return v[DIFF_W-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [CNT_W-1:0] clamp_cnt(logic [CNT_W-1:0] v, int hi);
      logic [CNT_W-1:0] r;
      r = v;
      if (v < CNT_W'(2)) r = CNT_W'(2);
      if (v > CNT_W'(hi)) r = CNT_W'(hi);
      return r;
   endfunction

   // Configuration registers
   logic [CNT_W-1:0] count_x_ff, count_y_ff;
   logic             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_x_ff <= CNT_W'(2);
         count_y_ff <= CNT_W'(2);
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            CSR_IDX_COUNT_X: count_x_ff <= clamp_cnt(csr_pwdata[CNT_W-1:0], MAX_X);
            CSR_IDX_COUNT_Y: count_y_ff <= clamp_cnt(csr_pwdata[CNT_W-1:0], MAX_Y);
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_IDX_COUNT_X: csr_prdata = PDATA_W'(count_x_ff);
         CSR_IDX_COUNT_Y: csr_prdata = PDATA_W'(count_y_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // Request fields
   logic [IX_W-1:0]  in_ix;
   logic [IY_W-1:0]  in_iy;
   logic [VAL_W-1:0] in_cx, in_cy, in_dv;
   req_kind_type     in_kind;
   logic             req_acc;

   assign in_ix   = req_tdata[5:0];
   assign in_iy   = req_tdata[11:6];
   assign in_cx   = req_tdata[43:12];
   assign in_cy   = req_tdata[75:44];
   assign in_dv   = req_tdata[107:76];
   assign in_kind = req_kind_type'(req_tuser);

   fsm_state_type state_ff, state_in;

   assign req_tready = state_ff == S_IDLE;
   assign req_acc    = req_tvalid && req_tready;

   // Memories
   logic              x_we, y_we, z_we;
   logic [IX_W-1:0]   x_wa, x_ra;
   logic [IY_W-1:0]   y_wa, y_ra;
   logic [GADDR_W-1:0] z_wa, z_ra;
   logic [VAL_W-1:0]  x_wd, y_wd, z_wd, x_rd, y_rd, z_rd;

   bgi_ram #(.DEPTH(MAX_X), .WIDTH(VAL_W)) u_axis_x (
      .clock(clock), .wr_en(x_we), .wr_addr(x_wa), .wr_data(x_wd),
      .rd_addr(x_ra), .rd_data(x_rd));

   bgi_ram #(.DEPTH(MAX_Y), .WIDTH(VAL_W)) u_axis_y (
      .clock(clock), .wr_en(y_we), .wr_addr(y_wa), .wr_data(y_wd),
      .rd_addr(y_ra), .rd_data(y_rd));

   bgi_ram #(.DEPTH(GRID_DEPTH), .WIDTH(VAL_W)) u_grid (
      .clock(clock), .wr_en(z_we), .wr_addr(z_wa), .wr_data(z_wd),
      .rd_addr(z_ra), .rd_data(z_rd));

   // Divider
   logic              div_start, div_done;
   logic [ACC_W-1:0]  div_num, div_quot;
   logic [DEN_W-1:0]  div_den, div_rem;

   bgi_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .done(div_done), .quot(div_quot), .rem(div_rem));

   // Item registers
   logic [IX_W-1:0]  ix_ff, i1_ff, i2_ff;
   logic [IY_W-1:0]  iy_ff, j1_ff, j2_ff;
   logic [VAL_W-1:0] cx_ff, cy_ff, dv_ff, x0_ff, y0_ff, yl_ff;
   logic [VAL_W-1:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic [VAL_W-1:0] z_ff [4];
   logic [1:0]       zcnt_ff, ph_ff;
   logic [2:0]       tcnt_ff;
   logic             oorx_ff, den_neg_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [PART_W-1:0]        p_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [VAL_W-1:0]  val_ff, res_val_ff;
   logic [STAT_W-1:0] stat_ff, res_stat_ff;
   logic              rsp_valid_ff, out_free, out_load;

   // Index arithmetic
   logic [CNT_W-1:0]  top_x, top_y, top_c;
   logic [IDXN_W-1:0] idx_num_x, idx_num_y;
   logic              oor_c;
   logic [IX_W-1:0]   k1_c, k2_c;
   logic              degen_end, degen_pts;

   assign top_x = count_x_ff - 1'b1;
   assign top_y = count_y_ff - 1'b1;
   assign idx_num_x = IDXN_W'(mag33(sdiff(cx_ff, x0_ff))) * IDXN_W'(top_x);
   assign idx_num_y = IDXN_W'(mag33(sdiff(cy_ff, y0_ff))) * IDXN_W'(top_y);
   assign top_c = (state_ff == S_DIVX) ? top_x : top_y;
   assign oor_c = (div_quot > ACC_W'(top_c)) ||
                  ((div_quot == ACC_W'(top_c)) && (div_rem != '0));
   assign k1_c  = div_quot[IX_W-1:0];
   assign k2_c  = ((div_rem == '0) && (div_quot[CNT_W-1:0] == top_c)) ?
                  (div_quot[IX_W-1:0] - 1'b1) : (div_quot[IX_W-1:0] + 1'b1);
   assign degen_end = (x_rd == x0_ff) || (y_rd == y0_ff);
   assign degen_pts = (x_rd == x1_ff) || (y_rd == y1_ff);

   // Multiplier operands
   logic [DIFF_W-1:0]       dx_c, dy_c;
   logic [VAL_W-1:0]        z_sel;
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic [ACC_W-1:0]        acc_mag;
   logic [PART_W-1:0]       den_mag;

   assign dx_c  = tcnt_ff[2] ? sdiff(x2_ff, x1_ff) :
                  (tcnt_ff[0] ? sdiff(cx_ff, x1_ff) : sdiff(x2_ff, cx_ff));
   assign dy_c  = tcnt_ff[2] ? sdiff(y2_ff, y1_ff) :
                  (tcnt_ff[1] ? sdiff(cy_ff, y1_ff) : sdiff(y2_ff, cy_ff));
   assign z_sel = z_ff[tcnt_ff[1:0]];
   assign acc_mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign den_mag = prod_ff[PART_W-1] ? (~prod_ff[PART_W-1:0] + 1'b1) : prod_ff[PART_W-1:0];

   always_comb begin
      case (ph_ff)
         2'd0: begin
            mul_a = signed'({dy_c[DIFF_W-1], dy_c});
            mul_b = signed'({dx_c[DIFF_W-1], dx_c});
         end
         2'd1: begin
            mul_a = signed'({1'b0, prod_ff[DIFF_W-1:0]});
            mul_b = signed'({{2{z_sel[VAL_W-1]}}, z_sel});
         end
         2'd2: begin
            mul_a = signed'({p_ff[PART_W-1], p_ff[PART_W-1:DIFF_W]});
            mul_b = signed'({{2{z_sel[VAL_W-1]}}, z_sel});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Final saturation
   logic              q_hi_zero, res_neg;
   logic [VAL_W-1:0]  res_c;

   assign q_hi_zero = div_quot[ACC_W-1:VAL_W] == '0;
   assign res_neg   = acc_ff[ACC_W-1] ^ den_neg_ff;
   always_comb begin
      if (!res_neg) begin
         res_c = (!q_hi_zero || div_quot[VAL_W-1]) ? 32'h7FFF_FFFF : div_quot[VAL_W-1:0];
      end else if (!q_hi_zero || (div_quot[VAL_W-1] && (div_quot[VAL_W-2:0] != '0))) begin
         res_c = 32'h8000_0000;
      end else begin
         res_c = -div_quot[VAL_W-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign out_load = (state_ff == S_OUT) && out_free;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc && in_kind == RT_ADD_Z) state_in = S_ADD;
            else if (req_acc && in_kind == RT_QUERY) state_in = S_END0;
         end
         S_ADD:  state_in = S_IDLE;
         S_END0: state_in = S_END1;
         S_END1: state_in = degen_end ? S_OUT : S_DIVX;
         S_DIVX: if (div_done) state_in = S_DIVY;
         S_DIVY: if (div_done) state_in = (oorx_ff || oor_c) ? S_OUT : S_RDA;
         S_RDA:  state_in = S_RDB;
         S_RDB:  state_in = S_RDC;
         S_RDC:  state_in = degen_pts ? S_OUT : S_RDZ;
         S_RDZ:  if (zcnt_ff == 2'd3) state_in = S_MUL;
         S_MUL:  if (ph_ff == 2'd1 && tcnt_ff[2]) state_in = S_DIVZ;
         S_DIVZ: if (div_done) state_in = S_OUT;
         S_OUT:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Memory and divider controls
   always_comb begin
      x_we = 1'b0;  x_wa = in_ix;  x_wd = in_cx;  x_ra = '0;
      y_we = 1'b0;  y_wa = in_iy;  y_wd = in_cy;  y_ra = '0;
      z_we = 1'b0;  z_wa = {in_ix, in_iy};  z_wd = in_dv;  z_ra = {in_ix, in_iy};
      div_start = 1'b0;
      div_num   = ACC_W'(idx_num_x);
      div_den   = DEN_W'(mag33(sdiff(x_rd, x0_ff)));
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               x_we = (in_kind == RT_WRITE_X) || (in_kind == RT_WRITE_ALL);
               y_we = (in_kind == RT_WRITE_Y) || (in_kind == RT_WRITE_ALL);
               z_we = (in_kind == RT_WRITE_Z) || (in_kind == RT_WRITE_ALL);
            end
         end
         S_ADD: begin
            z_we = 1'b1;
            z_wa = {ix_ff, iy_ff};
            z_wd = z_rd + dv_ff;
         end
         S_END0: begin
            x_ra = top_x[IX_W-1:0];
            y_ra = top_y[IY_W-1:0];
         end
         S_END1: div_start = !degen_end;
         S_DIVX: begin
            div_start = div_done;
            div_num   = ACC_W'(idx_num_y);
            div_den   = DEN_W'(mag33(sdiff(yl_ff, y0_ff)));
         end
         S_RDA: begin
            x_ra = i1_ff;
            y_ra = j1_ff;
         end
         S_RDB: begin
            x_ra = i2_ff;
            y_ra = j2_ff;
         end
         S_RDC: z_ra = {i1_ff, j1_ff};
         S_RDZ: begin
            z_ra = {(zcnt_ff == 2'd0 || zcnt_ff == 2'd2) ? i2_ff : i1_ff,
                    zcnt_ff[1] || zcnt_ff == 2'd1 ? j2_ff : j1_ff};
         end
         S_MUL: begin
            div_start = (ph_ff == 2'd1) && tcnt_ff[2];
            div_num   = acc_mag;
            div_den   = den_mag;
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         zcnt_ff      <= '0;
         tcnt_ff      <= '0;
         ph_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_RDA: begin
               zcnt_ff <= '0;
               tcnt_ff <= '0;
               ph_ff   <= '0;
            end
            S_RDZ: zcnt_ff <= zcnt_ff + 1'b1;
            S_MUL: begin
               ph_ff <= ph_ff + 1'b1;
               if (ph_ff == 2'd3) tcnt_ff <= tcnt_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (out_load) begin
         res_val_ff  <= val_ff;
         res_stat_ff <= stat_ff;
      end
      case (state_ff)
         S_IDLE: begin
            ix_ff <= in_ix;
            iy_ff <= in_iy;
            cx_ff <= in_cx;
            cy_ff <= in_cy;
            dv_ff <= in_dv;
         end
         S_END0: begin
            x0_ff <= x_rd;
            y0_ff <= y_rd;
         end
         S_END1: begin
            yl_ff  <= y_rd;
            val_ff <= '0;
            stat_ff <= STAT_DEGEN;
         end
         S_DIVX: begin
            oorx_ff <= oor_c;
            i1_ff   <= k1_c;
            i2_ff   <= k2_c;
         end
         S_DIVY: begin
            j1_ff   <= k1_c;
            j2_ff   <= k2_c;
            stat_ff <= STAT_RANGE;
         end
         S_RDA: acc_ff <= '0;
         S_RDB: begin
            x1_ff <= x_rd;
            y1_ff <= y_rd;
         end
         S_RDC: begin
            x2_ff   <= x_rd;
            y2_ff   <= y_rd;
            stat_ff <= STAT_DEGEN;
         end
         S_RDZ: z_ff[zcnt_ff] <= z_rd;
         S_MUL: begin
            case (ph_ff)
               2'd1: begin
                  p_ff       <= prod_ff[PART_W-1:0];
                  den_neg_ff <= prod_ff[PART_W-1];
               end
               2'd2: acc_ff <= acc_ff + ACC_W'(prod_ff);
               2'd3: acc_ff <= acc_ff + (ACC_W'(prod_ff) <<< DIFF_W);
               default: ;
            endcase
         end
         S_DIVZ: begin
            val_ff  <= res_c;
            stat_ff <= STAT_OK;
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, res_stat_ff, res_val_ff};

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result appeared outside the output state");

   a_zero_unless_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && res_stat_ff != STAT_OK) |-> (res_val_ff == '0))
      else $error("nonzero value with failing status");

   a_counts_in_range: assert property (@(posedge clock) disable iff (reset)
      (count_x_ff >= CNT_W'(2)) && (count_x_ff <= CNT_W'(MAX_X)) &&
      (count_y_ff >= CNT_W'(2)) && (count_y_ff <= CNT_W'(MAX_Y)))
      else $error("grid count out of range");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |=> !div_done)
      else $error("divider finished right after a start");

endmodule
